>>> src/rv64es_pkg.sv
// Package for the RV64I execute step: opcodes, event and memory codes,
// and the packed transaction layouts shared by the stages and the checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rv64es_pkg;

  // Major opcodes of the base integer set
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OPIMM32 = 7'h1B;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP32   = 7'h3B;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [5:0] F6_BASE = 6'h00;
  localparam logic [5:0] F6_ALT  = 6'h10;

  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;
  localparam logic [11:0] SYS_WFI    = 12'h105;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_MISALIGN  = 3'd1;
  localparam logic [2:0] EV_ILLEGAL   = 3'd2;
  localparam logic [2:0] EV_BREAK     = 3'd3;
  localparam logic [2:0] EV_ECALL     = 3'd4;
  localparam logic [2:0] EV_CSR       = 3'd5;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] SZ_BYTE   = 2'd0;
  localparam logic [1:0] SZ_HALF   = 2'd1;
  localparam logic [1:0] SZ_WORD   = 2'd2;
  localparam logic [1:0] SZ_DOUBLE = 2'd3;

  localparam int IN_BITS  = 224;
  localparam int OUT_BITS = 336;

  // Input transaction, last field in the lowest bits
  typedef struct packed {
    logic [63:0] rs2_value;
    logic [63:0] rs1_value;
    logic [31:0] instruction;
    logic [63:0] pc;
  } exec_in_t;

  // Result transaction, last field in the lowest bits
  typedef struct packed {
    logic [1:0]  pad;
    logic [63:0] trap_value;
    logic [2:0]  event_res;
    logic [63:0] store_data;
    logic [63:0] mem_addr;
    logic        mem_unsigned;
    logic [1:0]  mem_size;
    logic [1:0]  mem_op;
    logic [63:0] rd_value;
    logic [4:0]  rd_index;
    logic        rd_write;
    logic [63:0] next_pc;
  } exec_out_t;

endpackage

`default_nettype wire

>>> src/rv64es_exec.sv
// Combinational decode and execute of one RV64I instruction.
// Depends on rv64es_pkg for opcodes, codes and transaction layouts.
`timescale 1ns / 1ps
`default_nettype none

module rv64es_exec (
  input  rv64es_pkg::exec_in_t  item,
  input  logic [63:0]           trap_vector,
  output rv64es_pkg::exec_out_t res
);
  import rv64es_pkg::*;

  always_comb begin
    logic [31:0] insn;
    logic [63:0] pc, a, b;
    logic [6:0]  op, f7;
    logic [5:0]  f6;
    logic [4:0]  rd, rs1, sh5, s5;
    logic [5:0]  sh6, s6;
    logic [2:0]  f3;
    logic [63:0] imm_i, imm_s, imm_b, imm_u, imm_j;
    logic [63:0] npc, val, maddr, sdata, tval;
    logic [31:0] w;
    logic        wr, mun, ill, taken;
    logic [4:0]  rdi;
    logic [1:0]  mop, msz;
    logic [2:0]  ev;

    insn  = item.instruction;
    pc    = item.pc;
    a     = item.rs1_value;
    b     = item.rs2_value;
    op    = insn[6:0];
    rd    = insn[11:7];
    f3    = insn[14:12];
    rs1   = insn[19:15];
    f7    = insn[31:25];
    f6    = insn[31:26];
    sh5   = insn[24:20];
    sh6   = insn[25:20];
    s5    = b[4:0];
    s6    = b[5:0];
    imm_i = {{52{insn[31]}}, insn[31:20]};
    imm_s = {{52{insn[31]}}, insn[31:25], insn[11:7]};
    imm_b = {{51{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
    imm_u = {{32{insn[31]}}, insn[31:12], 12'b0};
    imm_j = {{43{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};

    npc   = pc + 64'd4;
    val   = '0;
    maddr = '0;
    sdata = '0;
    tval  = '0;
    w     = '0;
    wr    = 1'b0;
    mun   = 1'b0;
    ill   = 1'b0;
    taken = 1'b0;
    rdi   = '0;
    mop   = MEM_NONE;
    msz   = SZ_BYTE;
    ev    = EV_NONE;

    if (pc[1:0] != 2'b00) begin
      ev   = EV_MISALIGN;
      tval = pc;
    end else begin
      case (op)
        OPC_LUI: begin
          wr  = 1'b1;
          val = imm_u;
        end
        OPC_AUIPC: begin
          wr  = 1'b1;
          val = pc + imm_u;
        end
        OPC_JAL: begin
          wr  = 1'b1;
          val = pc + 64'd4;
          npc = pc + imm_j;
        end
        OPC_JALR: begin
          if (f3 != 3'd0) begin
            ill = 1'b1;
          end else begin
            wr  = 1'b1;
            val = pc + 64'd4;
            npc = (a + imm_i) & ~64'd1;
          end
        end
        OPC_BRANCH: begin
          case (f3)
            3'd0:    taken = (a == b);
            3'd1:    taken = (a != b);
            3'd4:    taken = ($signed(a) < $signed(b));
            3'd5:    taken = !($signed(a) < $signed(b));
            3'd6:    taken = (a < b);
            3'd7:    taken = (a >= b);
            default: ill = 1'b1;
          endcase
          if (taken) npc = pc + imm_b;
        end
        OPC_LOAD: begin
          if (f3 == 3'd7) begin
            ill = 1'b1;
          end else begin
            mop   = MEM_LOAD;
            msz   = f3[1:0];
            mun   = f3[2];
            maddr = a + imm_i;
            rdi   = rd;
          end
        end
        OPC_STORE: begin
          if (f3[2]) begin
            ill = 1'b1;
          end else begin
            mop   = MEM_STORE;
            msz   = f3[1:0];
            maddr = a + imm_s;
            case (f3[1:0])
              SZ_BYTE: sdata = {56'b0, b[7:0]};
              SZ_HALF: sdata = {48'b0, b[15:0]};
              SZ_WORD: sdata = {32'b0, b[31:0]};
              default: sdata = b;
            endcase
          end
        end
        OPC_OPIMM: begin
          wr = 1'b1;
          case (f3)
            3'd0: val = a + imm_i;
            3'd2: val = {63'b0, $signed(a) < $signed(imm_i)};
            3'd3: val = {63'b0, a < imm_i};
            3'd4: val = a ^ imm_i;
            3'd6: val = a | imm_i;
            3'd7: val = a & imm_i;
            3'd1: begin
              if (f6 != F6_BASE) ill = 1'b1;
              else val = a << sh6;
            end
            default: begin
              if (f6 == F6_BASE) val = a >> sh6;
              else if (f6 == F6_ALT) val = $unsigned($signed(a) >>> sh6);
              else ill = 1'b1;
            end
          endcase
        end
        OPC_OPIMM32: begin
          wr = 1'b1;
          if (f3 == 3'd0) w = a[31:0] + imm_i[31:0];
          else if (f3 == 3'd1 && f7 == F7_BASE) w = a[31:0] << sh5;
          else if (f3 == 3'd5 && f7 == F7_BASE) w = a[31:0] >> sh5;
          else if (f3 == 3'd5 && f7 == F7_ALT) w = $unsigned($signed(a[31:0]) >>> sh5);
          else ill = 1'b1;
          val = {{32{w[31]}}, w};
        end
        OPC_OP: begin
          wr = 1'b1;
          if (f7 == F7_ALT) begin
            if (f3 == 3'd0) val = a - b;
            else if (f3 == 3'd5) val = $unsigned($signed(a) >>> s6);
            else ill = 1'b1;
          end else if (f7 == F7_BASE) begin
            case (f3)
              3'd0:    val = a + b;
              3'd1:    val = a << s6;
              3'd2:    val = {63'b0, $signed(a) < $signed(b)};
              3'd3:    val = {63'b0, a < b};
              3'd4:    val = a ^ b;
              3'd5:    val = a >> s6;
              3'd6:    val = a | b;
              default: val = a & b;
            endcase
          end else begin
            ill = 1'b1;
          end
        end
        OPC_OP32: begin
          wr = 1'b1;
          if (f3 == 3'd0 && f7 == F7_BASE) w = a[31:0] + b[31:0];
          else if (f3 == 3'd0 && f7 == F7_ALT) w = a[31:0] - b[31:0];
          else if (f3 == 3'd1 && f7 == F7_BASE) w = a[31:0] << s5;
          else if (f3 == 3'd5 && f7 == F7_BASE) w = a[31:0] >> s5;
          else if (f3 == 3'd5 && f7 == F7_ALT) w = $unsigned($signed(a[31:0]) >>> s5);
          else ill = 1'b1;
          val = {{32{w[31]}}, w};
        end
        OPC_SYSTEM: begin
          if (f3 == 3'd0) begin
            if (rd != 5'd0 || rs1 != 5'd0) ill = 1'b1;
            else if (insn[31:20] == SYS_ECALL) ev = EV_ECALL;
            else if (insn[31:20] == SYS_EBREAK) ev = EV_BREAK;
            else if (insn[31:20] != SYS_WFI) ill = 1'b1;
          end else if (f3 == 3'd4) begin
            ill = 1'b1;
          end else begin
            ev   = EV_CSR;
            tval = {32'b0, insn};
          end
        end
        default: ill = 1'b1;
      endcase
      if (ill) begin
        ev   = EV_ILLEGAL;
        tval = {32'b0, insn};
      end
    end

    // Events win over everything: redirect and drop all side effects
    if (ev != EV_NONE) begin
      npc = trap_vector;
      wr  = 1'b0;
      rdi = '0;
      mop = MEM_NONE;
    end else if (wr) begin
      if (rd == 5'd0) wr = 1'b0;
      else rdi = rd;
    end
    if (!wr) val = '0;
    if (mop == MEM_NONE) begin
      msz   = SZ_BYTE;
      mun   = 1'b0;
      maddr = '0;
      sdata = '0;
    end

    res.pad          = '0;
    res.trap_value   = tval;
    res.event_res    = ev;
    res.store_data   = sdata;
    res.mem_addr     = maddr;
    res.mem_unsigned = mun;
    res.mem_size     = msz;
    res.mem_op       = mop;
    res.rd_value     = val;
    res.rd_index     = rdi;
    res.rd_write     = wr;
    res.next_pc      = npc;
  end

endmodule

`default_nettype wire

>>> src/rv64i_execute_step.sv
// Top level of the RV64I execute step: input register, execute logic and
// result register. Depends on rv64es_pkg and rv64es_exec.
//
// Usage:
//   Slave stream (s_axis_*) takes one instruction transaction: pc, the
//   instruction word and both source register values. Master stream
//   (m_axis_*) returns one result transaction for each: next pc, register
//   write, memory request and trap event.
//   The trap vector is loaded through cfg_wr_en / cfg_wr_data; write it only
//   while no transaction is in flight.
//   Path: an accepted transaction goes into the input register and then,
//   once the result register can move, into the result register, from
//   which the result is offered on the master stream.
//   Throughput: one transaction per cycle while m_axis_tready is high; the
//   whole decode and execute is one combinational pass between the registers.
//   Stall: when the receiver holds m_axis_tready low, the result register
//   holds; the input register still fills while it is empty, so one more
//   transaction is taken before s_axis_tready drops.
//   Reset (rst, synchronous, active high): both stages empty, trap vector 0.
`timescale 1ns / 1ps
`default_nettype none

module rv64i_execute_step (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: trap vector
  input  logic                            cfg_wr_en,
  input  logic [63:0]                     cfg_wr_data,
  // Instruction stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pc[63:0], instruction[95:64], rs1_value[159:96], rs2_value[223:160]
  input  logic [rv64es_pkg::IN_BITS-1:0]  s_axis_tdata,
  // Result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // next_pc[63:0], rd_write[64], rd_index[69:65], rd_value[133:70],
  // mem_op[135:134], mem_size[137:136], mem_unsigned[138],
  // mem_addr[202:139], store_data[266:203], event_res[269:267],
  // trap_value[333:270], zero pad[335:334]
  output logic [rv64es_pkg::OUT_BITS-1:0] m_axis_tdata
);
  import rv64es_pkg::*;

  logic [63:0] trap_vector;
  logic        in_valid;
  exec_in_t    in_data;
  logic        out_valid;
  exec_out_t   out_data;
  exec_out_t   exec_res;
  logic        out_advance;

  // Result register moves when empty or being drained
  assign out_advance   = !out_valid || m_axis_tready;
  // Input register takes a new transaction when empty or moving on
  assign s_axis_tready = !in_valid || out_advance;

  rv64es_exec u_exec (
    .item        (in_data),
    .trap_vector (trap_vector),
    .res         (exec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      trap_vector <= '0;
      in_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) trap_vector <= cfg_wr_data;
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (out_advance) out_valid <= in_valid;
    end
  end

  // Payload: capture on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) in_data <= exec_in_t'(s_axis_tdata);
    if (out_advance && in_valid) out_data <= exec_res;
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

`default_nettype wire

>>> src/rv64es_checker.sv
// Port-level checker for the RV64I execute step, bound to the top level.
// Depends on rv64es_pkg for result layout and codes.
`timescale 1ns / 1ps
`default_nettype none

module rv64es_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic [rv64es_pkg::OUT_BITS-1:0] m_axis_tdata
);
  import rv64es_pkg::*;

  exec_out_t r;
  assign r = exec_out_t'(m_axis_tdata);

  // x0 is never written
  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && r.rd_write) |-> (r.rd_index != 5'd0))
    else $error("register write to x0");

  // A trap drops the register write and the memory request
  a_event_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && r.event_res != EV_NONE) |->
      (!r.rd_write && r.mem_op == MEM_NONE && r.rd_value == 64'd0))
    else $error("side effect on trap");

  // No memory request leaves the request fields clear
  a_mem_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && r.mem_op == MEM_NONE) |->
      (r.mem_addr == 64'd0 && r.store_data == 64'd0 && r.mem_size == SZ_BYTE
       && !r.mem_unsigned))
    else $error("memory fields set without request");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind rv64i_execute_step rv64es_checker u_rv64es_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
